/* hw/rtl/epve_pkg.sv */
// ----------------------------------------------------------------------------
// epve_pkg
// Shared widths, constants, state encoding and a helper function for the
// two-wheel encoder period velocity estimator.
// ----------------------------------------------------------------------------
package epve_pkg;

    localparam int TS_W   = 64;   // timestamp width
    localparam int POS_W  = 32;   // position count width
    localparam int VEL_W  = 31;   // velocity width
    localparam int IDLE_W = 14;   // idle tick counter width
    localparam int Q_W    = 30;   // quotient / divisor width (1e9 < 2**30)
    localparam int CNT_W  = $clog2(Q_W);

    localparam int          IDLE_LIMIT_DEF = 10000;
    localparam logic [Q_W-1:0]  NS_PER_SEC = Q_W'(1000000000);
    localparam logic [TS_W-1:0] NS_PER_SEC_TS = TS_W'(1000000000);

    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic           start;
        logic [Q_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
    } t_div_rsp;

    // Scale by 31/32, truncating toward zero.
    function automatic logic signed [VEL_W-1:0] f_decay(input logic signed [VEL_W-1:0] v);
        logic signed [VEL_W+5:0] prod;
        logic signed [VEL_W+5:0] biased;
        logic signed [VEL_W+5:0] shifted;
        prod    = ($signed({v, 5'b0}) >>> 0) - (VEL_W+6)'(v);
        biased  = prod[VEL_W+5] ? prod + (VEL_W+6)'(31) : prod;
        shifted = biased >>> 5;
        return shifted[VEL_W-1:0];
    endfunction

endpackage

/* hw/rtl/epve_in_if.sv */
// ----------------------------------------------------------------------------
// epve_in_if
// Input channel: encoder edge events and control ticks.
// ----------------------------------------------------------------------------
interface epve_in_if;
    import epve_pkg::*;

    logic            valid;
    logic            ready;
    logic            mode;
    logic            wheel;
    logic [TS_W-1:0] timestamp_ns;
    logic            phase_a;
    logic            phase_b;

    modport source (
        output valid, mode, wheel, timestamp_ns, phase_a, phase_b,
        input  ready
    );

    modport sink (
        input  valid, mode, wheel, timestamp_ns, phase_a, phase_b,
        output ready
    );
endinterface

/* hw/rtl/epve_out_if.sv */
// ----------------------------------------------------------------------------
// epve_out_if
// Output channel: position, velocity and idle count of the reported wheel.
// ----------------------------------------------------------------------------
interface epve_out_if;
    import epve_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    out_wheel;
    logic signed [POS_W-1:0] position_count;
    logic signed [VEL_W-1:0] velocity_value;
    logic [IDLE_W-1:0]       idle_ticks;

    modport source (
        output valid, out_wheel, position_count, velocity_value, idle_ticks,
        input  ready
    );

    modport sink (
        input  valid, out_wheel, position_count, velocity_value, idle_ticks,
        output ready
    );
endinterface

/* hw/rtl/epve_div.sv */
// ----------------------------------------------------------------------------
// epve_div
// Radix-2 restoring divider: 1e9 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module epve_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  epve_pkg::t_div_req i_req,
    output epve_pkg::t_div_rsp o_rsp
);
    import epve_pkg::*;

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [Q_W-1:0]   r_rem, n_rem;
    logic [Q_W-1:0]   r_quo, n_quo;
    logic [Q_W-1:0]   r_dvs, n_dvs;
    logic             r_done, n_done;

    logic [Q_W:0]     trial;
    logic [Q_W+1:0]   diff;

    // shared subtract/compare step
    assign trial = {r_rem, NS_PER_SEC[r_cnt]};
    assign diff  = {1'b0, trial} - {2'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(Q_W - 1);
            n_rem  = '0;
            n_quo  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (diff[Q_W+1]) begin
                n_rem = trial[Q_W-1:0];
                n_quo = {r_quo[Q_W-2:0], 1'b0};
            end else begin
                n_rem = diff[Q_W-1:0];
                n_quo = {r_quo[Q_W-2:0], 1'b1};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

/* hw/rtl/encoder_period_velocity_estimator_unit.sv */
// ----------------------------------------------------------------------------
// encoder_period_velocity_estimator_unit
// Two-wheel quadrature encoder speed estimator: period-based velocity from
// edge timestamps, position count, and idle decay on control ticks.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Content
//  i_in     in   valid/ready   mode, wheel, timestamp_ns, phase_a, phase_b
//  o_out    out  valid/ready   out_wheel, position_count, velocity_value,
//                              idle_ticks
//
//  Edge item, from accept to result register: accept, divider load, 30
//  quotient steps of the shared restoring divider, write-back, result load.
//  Tick item: accept, result load. The divider loop sets the edge rate.
//  Reset (i_rst_n low, synchronous) clears all wheel state.
//  A new item is taken only in the idle state; a held result in the output
//  register stalls the sequencer before it returns to idle.
// ----------------------------------------------------------------------------
module encoder_period_velocity_estimator_unit #(
    parameter int IDLE_LIMIT = epve_pkg::IDLE_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    epve_in_if.sink    i_in,
    epve_out_if.source o_out
);
    import epve_pkg::*;

    localparam logic [IDLE_W-1:0] IdleLimit = IDLE_W'(IDLE_LIMIT);

    // sequencer
    t_state r_state, n_state;

    // per-wheel state
    logic signed [POS_W-1:0] r_edge_count [2];
    logic [TS_W-1:0]         r_last_time  [2];
    logic signed [VEL_W-1:0] r_speed      [2];
    logic [IDLE_W-1:0]       r_idle       [2];

    // latched item context
    logic            r_wheel;
    logic [TS_W-1:0] r_ts;
    logic            r_up;
    logic            r_slow;
    logic [Q_W-1:0]  r_divisor;

    // output register
    logic                    r_out_valid;
    logic                    r_out_wheel;
    logic signed [POS_W-1:0] r_out_pos;
    logic signed [VEL_W-1:0] r_out_vel;
    logic [IDLE_W-1:0]       r_out_idle;

    logic in_ready, in_take, out_free, out_load;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [TS_W-1:0]         dt;
    logic [VEL_W-1:0]        mag;
    logic signed [VEL_W-1:0] vel_new;

    epve_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // interval since this wheel's last edge; a zero interval counts as one
    assign dt = i_in.timestamp_ns - r_last_time[i_in.wheel];

    // quotient is zero once the interval exceeds one second
    assign mag     = r_slow ? '0 : {1'b0, div_rsp.quotient};
    assign vel_new = r_up ? $signed(mag) : -$signed(mag);

    assign out_free = !r_out_valid || o_out.ready;
    assign in_take  = i_in.valid && in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in.valid) begin
                n_state = (i_in.mode == MODE_TICK) ? ST_DONE : ST_LOAD;
            end
            ST_LOAD: n_state = ST_DIV;
            ST_DIV:  if (div_rsp.done) begin
                n_state = ST_DONE;
            end
            ST_DONE: if (out_free) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready        = 1'b0;
        div_req.start   = 1'b0;
        div_req.divisor = r_divisor;
        out_load        = 1'b0;
        unique case (r_state)
            ST_IDLE: in_ready      = 1'b1;
            ST_LOAD: div_req.start = 1'b1;
            ST_DIV:  ;
            ST_DONE: out_load      = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latch the item context on accept
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_wheel   <= (i_in.mode == MODE_TICK) ? 1'b0 : i_in.wheel;
            r_ts      <= i_in.timestamp_ns;
            r_up      <= (i_in.phase_a == i_in.phase_b);
            r_slow    <= (dt > NS_PER_SEC_TS);
            r_divisor <= (dt == '0) ? Q_W'(1) : dt[Q_W-1:0];
        end
    end

    // wheel state: decay and idle count on a tick, write back on divider completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < 2; w++) begin
                r_edge_count[w] <= '0;
                r_last_time[w]  <= '0;
                r_speed[w]      <= '0;
                r_idle[w]       <= '0;
            end
        end else if (in_take && i_in.mode == MODE_TICK) begin
            for (int w = 0; w < 2; w++) begin
                if (r_idle[w] != '0) begin
                    r_speed[w] <= f_decay(r_speed[w]);
                end
                if (r_idle[w] < IdleLimit) begin
                    r_idle[w] <= r_idle[w] + 1'b1;
                end
            end
        end else if (r_state == ST_DIV && div_rsp.done) begin
            r_last_time[r_wheel]  <= r_ts;
            r_edge_count[r_wheel] <= r_up ? r_edge_count[r_wheel] + 1
                                          : r_edge_count[r_wheel] - 1;
            r_speed[r_wheel]      <= vel_new;
            r_idle[r_wheel]       <= '0;
        end
    end

    // output register: hold until taken, load from the reported wheel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_wheel <= r_wheel;
            r_out_pos   <= r_edge_count[r_wheel];
            r_out_vel   <= r_speed[r_wheel];
            r_out_idle  <= r_idle[r_wheel];
        end
    end

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.out_wheel      = r_out_wheel;
    assign o_out.position_count = r_out_pos;
    assign o_out.velocity_value = r_out_vel;
    assign o_out.idle_ticks     = r_out_idle;
endmodule

/* tb/encoder_period_velocity_estimator_unit_test.sv */
// ----------------------------------------------------------------------------
// encoder_period_velocity_estimator_unit_test
// Self-checking bench for the two-wheel encoder velocity estimator. A
// scoreboard class tracks both wheels' position, period velocity and idle
// count, predicts the report for every accepted item and compares it with
// the output channel. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module encoder_period_velocity_estimator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import epve_pkg::*;

    localparam int          IDLE_MAX      = IDLE_LIMIT_DEF;
    localparam int          RANDOM_ITEMS  = 1700;
    localparam int          SAT_TICKS     = IDLE_MAX + 12;
    localparam int          STALL_LIMIT   = 2000;   // cycles with no handshake
    localparam int          DRAIN_CYCLES  = 40;
    localparam logic [63:0] ONE_SECOND_NS = 64'd1000000000;

    typedef struct {
        logic        mode;
        logic        wheel;
        logic [63:0] timestamp_ns;
        logic        phase_a;
        logic        phase_b;
    } t_encoder_item;

    typedef struct {
        logic                    out_wheel;
        logic signed [POS_W-1:0] position_count;
        logic signed [VEL_W-1:0] velocity_value;
        logic [IDLE_W-1:0]       idle_ticks;
    } t_wheel_report;

    // Track both wheels and hold the reports still owed by the block.
    class wheel_scoreboard;
        logic signed [POS_W-1:0] position[2];
        logic [63:0]             last_stamp[2];
        logic signed [VEL_W-1:0] velocity[2];
        logic [IDLE_W-1:0]       idle_count[2];
        t_wheel_report           owed_reports[$];
        int unsigned             mismatches;
        int unsigned             checked;
        int unsigned             saturated_seen;
        int unsigned             zero_intervals;

        function new();
            for (int w = 0; w < 2; w++) begin
                position[w]   = '0;
                last_stamp[w] = '0;
                velocity[w]   = '0;
                idle_count[w] = '0;
            end
            mismatches     = 0;
            checked        = 0;
            saturated_seen = 0;
            zero_intervals = 0;
        endfunction

        function int unsigned pending();
            return owed_reports.size();
        endfunction

        // Scale a velocity by 31/32, truncating toward zero.
        function logic signed [VEL_W-1:0] decayed(logic signed [VEL_W-1:0] v);
            longint scaled;
            scaled = longint'(v) * 31;
            scaled = scaled / 32;
            return scaled[VEL_W-1:0];
        endfunction

        // Apply one accepted item and queue the report it causes.
        function void note_item(t_encoder_item it);
            t_wheel_report rep;
            logic [63:0]   interval;
            logic [63:0]   rate;
            int            w;
            if (it.mode == MODE_EDGE) begin
                w        = int'(it.wheel);
                interval = it.timestamp_ns - last_stamp[w];
                if (interval == 64'd0) begin
                    interval = 64'd1;
                    zero_intervals++;
                end
                rate          = ONE_SECOND_NS / interval;
                last_stamp[w] = it.timestamp_ns;
                if (it.phase_a == it.phase_b) begin
                    position[w] = position[w] + 1;
                    velocity[w] = rate[VEL_W-1:0];
                end else begin
                    position[w] = position[w] - 1;
                    velocity[w] = -rate[VEL_W-1:0];
                end
                idle_count[w] = '0;
            end else begin
                w = 0;
                for (int k = 0; k < 2; k++) begin
                    if (idle_count[k] != '0)
                        velocity[k] = decayed(velocity[k]);
                    if (idle_count[k] < IDLE_W'(IDLE_MAX))
                        idle_count[k] = idle_count[k] + 1'b1;
                end
            end
            rep.out_wheel      = (it.mode == MODE_EDGE) ? it.wheel : 1'b0;
            rep.position_count = position[w];
            rep.velocity_value = velocity[w];
            rep.idle_ticks     = idle_count[w];
            owed_reports.push_back(rep);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            mismatches++;
            if (mismatches <= 100)
                $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        endtask

        // Compare one report from the block with the oldest owed one.
        task check_report(t_wheel_report got);
            t_wheel_report want;
            if (owed_reports.size() == 0) begin
                report_mismatch("report with nothing owed, wheel", got.out_wheel, -1);
                return;
            end
            want = owed_reports.pop_front();
            checked++;
            if (got.idle_ticks == IDLE_W'(IDLE_MAX))
                saturated_seen++;
            if (got.out_wheel !== want.out_wheel)
                report_mismatch("out_wheel", got.out_wheel, want.out_wheel);
            if (got.position_count !== want.position_count)
                report_mismatch("position_count", got.position_count, want.position_count);
            if (got.velocity_value !== want.velocity_value)
                report_mismatch("velocity_value", got.velocity_value, want.velocity_value);
            if (got.idle_ticks !== want.idle_ticks)
                report_mismatch("idle_ticks", got.idle_ticks, want.idle_ticks);
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    epve_in_if  in_if ();
    epve_out_if out_if ();

    encoder_period_velocity_estimator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    always #5 i_clk = ~i_clk;

    wheel_scoreboard sb;
    bit              steady;           // suppress idling on both sides
    int unsigned     quiet_cycles;
    int unsigned     edge_items;
    int unsigned     tick_items;
    int unsigned     noise_items;
    logic [63:0]     wheel_clock[2];   // generator's running time per wheel

    // Pick an idle length: mostly none, sometimes short, rarely long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one item, hold it until accepted, then maybe idle.
    task send_item(t_encoder_item it);
        int unsigned gap;
        in_if.valid        <= 1'b1;
        in_if.mode         <= it.mode;
        in_if.wheel        <= it.wheel;
        in_if.timestamp_ns <= it.timestamp_ns;
        in_if.phase_a      <= it.phase_a;
        in_if.phase_b      <= it.phase_b;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        if (it.mode == MODE_EDGE)
            edge_items++;
        else
            tick_items++;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task send_edge_event(logic w, logic [63:0] ts, logic a, logic b);
        t_encoder_item it;
        it.mode         = MODE_EDGE;
        it.wheel        = w;
        it.timestamp_ns = ts;
        it.phase_a      = a;
        it.phase_b      = b;
        wheel_clock[w]  = ts;
        send_item(it);
    endtask

    // Fill the ignored fields of a tick with random junk.
    task send_tick();
        t_encoder_item it;
        it.mode         = MODE_TICK;
        it.wheel        = 1'($urandom);
        it.timestamp_ns = {$urandom, $urandom};
        it.phase_a      = 1'($urandom);
        it.phase_b      = 1'($urandom);
        send_item(it);
    endtask

    // Drop valid and hold off until every owed report has come back.
    task wait_for_drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Draw one random item: mostly plausible edges on a running clock, some
    // ticks, and a little noise with arbitrary 64-bit timestamps.
    task send_random_item();
        int unsigned kind;
        int unsigned span;
        logic        w;
        logic [63:0] delta;
        kind = $urandom_range(0, 99);
        w    = 1'($urandom);
        if (kind < 14) begin
            send_tick();
        end else if (kind < 22) begin
            noise_items++;
            send_edge_event(w, {$urandom, $urandom}, 1'($urandom), 1'($urandom));
        end else begin
            span = $urandom_range(0, 99);
            if (span < 5)
                delta = 64'd0;
            else if (span < 35)
                delta = 64'($urandom_range(1, 4095));
            else if (span < 65)
                delta = 64'($urandom_range(4096, 1 << 20));
            else if (span < 90)
                delta = 64'($urandom_range(1, 100000000));
            else
                delta = ONE_SECOND_NS - 64'd100 + 64'($urandom_range(0, 1000000));
            send_edge_event(w, wheel_clock[w] + delta, 1'($urandom), 1'($urandom));
        end
    endtask

    // Sink side: alternate ready bursts with random stalls.
    initial begin
        int unsigned stall;
        out_if.ready = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Watch both channels: note accepted items, check reports, and end the
    // run if nothing moves for too long.
    always @(posedge i_clk) begin
        t_encoder_item it;
        t_wheel_report got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                it.mode         = in_if.mode;
                it.wheel        = in_if.wheel;
                it.timestamp_ns = in_if.timestamp_ns;
                it.phase_a      = in_if.phase_a;
                it.phase_b      = in_if.phase_b;
                sb.note_item(it);
            end
            if (out_if.valid && out_if.ready) begin
                got.out_wheel      = out_if.out_wheel;
                got.position_count = out_if.position_count;
                got.velocity_value = out_if.velocity_value;
                got.idle_ticks     = out_if.idle_ticks;
                sb.check_report(got);
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[%0t] timeout: no handshake for %0d cycles, %0d reports owed",
                         $time, STALL_LIMIT, sb.pending());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        sb                 = new();
        steady             = 1'b0;
        quiet_cycles       = 0;
        edge_items         = 0;
        tick_items         = 0;
        noise_items        = 0;
        wheel_clock[0]     = '0;
        wheel_clock[1]     = '0;
        in_if.valid        = 1'b0;
        in_if.mode         = MODE_EDGE;
        in_if.wheel        = 1'b0;
        in_if.timestamp_ns = '0;
        in_if.phase_a      = 1'b0;
        in_if.phase_b      = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first edges after reset at time zero, zero intervals,
        // wrap of the 64-bit difference, time going backward, slow edges.
        send_edge_event(1'b0, 64'd0, 1'b0, 1'b0);
        send_edge_event(1'b0, 64'd0, 1'b1, 1'b0);
        send_edge_event(1'b0, 64'd1000, 1'b1, 1'b1);
        send_edge_event(1'b1, 64'd1, 1'b0, 1'b1);
        send_edge_event(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        send_edge_event(1'b1, 64'd5, 1'b1, 1'b0);
        send_edge_event(1'b0, 64'd500, 1'b0, 1'b0);
        send_edge_event(1'b0, 64'd1000000500, 1'b0, 1'b0);
        send_edge_event(1'b0, 64'd2000000501, 1'b1, 1'b1);
        send_edge_event(1'b0, 64'd2000000504, 1'b0, 1'b0);
        // Ticks: first one only starts the idle count, later ones decay.
        send_tick();
        send_tick();
        send_tick();
        send_edge_event(1'b1, 64'd12, 1'b0, 1'b1);
        send_tick();
        send_tick();
        send_edge_event(1'b0, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 1'b0);
        send_edge_event(1'b0, 64'h8000_0000_0000_0000, 1'b0, 1'b1);
        send_tick();
        send_edge_event(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        send_tick();

        // Hold off until the block has caught up completely.
        wait_for_drain();

        // Run both idle counters into saturation without idling.
        steady = 1'b1;
        for (int n = 0; n < SAT_TICKS; n++)
            send_tick();
        steady = 1'b0;
        send_edge_event(1'b1, wheel_clock[1] + 64'd777, 1'b1, 1'b1);

        // Random traffic in stretches, some of them without any idling.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2) begin
                wait_for_drain();
                @(posedge i_clk);
            end
            send_random_item();
        end
        steady = 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d edge events (%0d with arbitrary timestamps) and %0d ticks.",
                 edge_items, noise_items, tick_items);
        $display("Checked %0d reports; %0d zero intervals, %0d saturated idle counts.",
                 sb.checked, sb.zero_intervals, sb.saturated_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
